/* src/spu_pkg.sv */
// spu_pkg: shared widths, types and register indexes for the smoothed phase unwrapper.
// No dependencies; every other file in src depends on this package.
package spu_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int TURN_FRAC_BITS = 16;
  localparam int REF_FRAC       = 16;
  localparam int COEFF_BITS     = 16;
  localparam int CFG_IDX_BITS   = 2;

  localparam int REF_BITS   = PHASE_BITS + REF_FRAC;
  localparam int WRAP_BITS  = TURN_FRAC_BITS + REF_FRAC;  // full period in ref units
  localparam int DIFF_BITS  = WRAP_BITS + 2;
  localparam int RES_BITS   = PHASE_BITS + 2;
  localparam int DREF_BITS  = PHASE_BITS + 1;
  localparam int PROD_BITS  = COEFF_BITS + 1 + DREF_BITS;
  localparam int NREF_BITS  = PROD_BITS + 1;

  localparam logic [COEFF_BITS-1:0] COEFF_RESET = COEFF_BITS'(58982);

  typedef logic signed [PHASE_BITS-1:0] phase_t;
  typedef logic signed [REF_BITS-1:0]   ref_t;
  typedef logic [COEFF_BITS-1:0]        coeff_t;
  typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SMOOTH_COEFF = 2'd0,
    CFG_HALF_TURN    = 2'd1
  } cfg_reg_t;

  // Per-item result of the unwrap datapath.
  typedef struct packed {
    phase_t phase_out;
    logic   saturated;
    ref_t   next_ref;
  } spu_result_t;

endpackage

/* src/spu_if.sv */
// spu_if: valid/ready channel interfaces for samples, results and register writes.
// Depends on spu_pkg for field types.
interface spu_in_if;
  logic            valid;
  logic            ready;
  spu_pkg::phase_t phase_in;
  logic            block_start;

  modport source (output valid, output phase_in, output block_start, input ready);
  modport sink   (input valid, input phase_in, input block_start, output ready);
endinterface

interface spu_out_if;
  logic            valid;
  logic            ready;
  spu_pkg::phase_t phase_out;
  logic            saturated;

  modport source (output valid, output phase_out, output saturated, input ready);
  modport sink   (input valid, input phase_out, input saturated, output ready);
endinterface

interface spu_cfg_if;
  logic              valid;
  logic              ready;
  spu_pkg::cfg_idx_t index;
  spu_pkg::coeff_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/spu_unwrap.sv */
// spu_unwrap: combinational unwrap and smoothing step for one sample.
// Depends on spu_pkg.
module spu_unwrap (
  input  spu_pkg::ref_t        smoothed_ref,
  input  spu_pkg::phase_t      phase_in,
  input  logic                 block_start,
  input  spu_pkg::coeff_t      smooth_coeff,
  input  logic                 half_turn_mode,
  output spu_pkg::spu_result_t result
);
  import spu_pkg::*;

  localparam logic signed [DIFF_BITS-1:0] HALF_FULL = DIFF_BITS'(1) << (WRAP_BITS - 1);
  localparam logic signed [DIFF_BITS-1:0] HALF_HALF = DIFF_BITS'(1) << (WRAP_BITS - 2);
  localparam logic signed [RES_BITS-1:0]  TURN_FULL = RES_BITS'(1) << TURN_FRAC_BITS;
  localparam logic signed [RES_BITS-1:0]  TURN_HALF = RES_BITS'(1) << (TURN_FRAC_BITS - 1);
  localparam logic signed [RES_BITS-1:0]  RES_MAX   = RES_BITS'({1'b0, {(PHASE_BITS-1){1'b1}}});
  localparam logic signed [RES_BITS-1:0]  RES_MIN   = -RES_MAX - RES_BITS'(1);
  localparam logic signed [NREF_BITS-1:0] NREF_MAX  = NREF_BITS'(RES_MAX) <<< REF_FRAC;
  localparam logic signed [NREF_BITS-1:0] NREF_MIN  = NREF_BITS'(RES_MIN) <<< REF_FRAC;

  ref_t                          ref_eff;
  logic [WRAP_BITS-1:0]          rm;
  logic [TURN_FRAC_BITS-1:0]     pm_q;
  logic signed [DIFF_BITS-1:0]   d;
  logic signed [DIFF_BITS-1:0]   half_p;
  logic signed [RES_BITS-1:0]    period;
  logic                          lower;
  logic                          raise;
  phase_t                        ref_hi;
  phase_t                        base;
  logic signed [RES_BITS-1:0]    res_w;
  phase_t                        res;
  logic                          sat_out;
  logic signed [DREF_BITS-1:0]   dref;
  logic signed [COEFF_BITS:0]    coeff_s;
  logic signed [PROD_BITS-1:0]   prod;
  logic [2*COEFF_BITS-1:0]       lo_prod;
  ref_t                          res_sh;
  logic signed [NREF_BITS-1:0]   nref_w;
  ref_t                          nref;
  logic                          sat_ref;

  always_comb begin
    ref_eff = block_start ? {phase_in, {REF_FRAC{1'b0}}} : smoothed_ref;

    // Floor remainders: top bit dropped in half-turn mode.
    rm   = {~half_turn_mode & ref_eff[WRAP_BITS-1], ref_eff[WRAP_BITS-2:0]};
    pm_q = {~half_turn_mode & phase_in[TURN_FRAC_BITS-1], phase_in[TURN_FRAC_BITS-2:0]};
    d    = DIFF_BITS'({pm_q, {REF_FRAC{1'b0}}}) - DIFF_BITS'(rm);

    // |d-P| < |d| exactly when d > P/2; |d+P| < |d| when d < -P/2. Ties stay put.
    half_p = half_turn_mode ? HALF_HALF : HALF_FULL;
    lower  = d > half_p;
    raise  = d < -half_p;
    period = half_turn_mode ? TURN_HALF : TURN_FULL;

    // Reference's period base in phase LSBs.
    ref_hi = ref_eff[REF_BITS-1:REF_FRAC];
    base   = {ref_hi[PHASE_BITS-1:TURN_FRAC_BITS], half_turn_mode & ref_hi[TURN_FRAC_BITS-1],
              {(TURN_FRAC_BITS-1){1'b0}}};
    res_w  = RES_BITS'(base) + RES_BITS'(pm_q);
    if (lower) begin
      res_w = res_w - period;
    end else if (raise) begin
      res_w = res_w + period;
    end

    sat_out = 1'b0;
    if (res_w > RES_MAX) begin
      res     = RES_MAX[PHASE_BITS-1:0];
      sat_out = 1'b1;
    end else if (res_w < RES_MIN) begin
      res     = RES_MIN[PHASE_BITS-1:0];
      sat_out = 1'b1;
    end else begin
      res = res_w[PHASE_BITS-1:0];
    end

    // ref' = c*(hi - out) + out*2^16 + floor(c*lo/2^16)
    dref    = DREF_BITS'(ref_hi) - DREF_BITS'(res);
    coeff_s = {1'b0, smooth_coeff};
    prod    = PROD_BITS'(coeff_s) * PROD_BITS'(dref);
    lo_prod = smooth_coeff * ref_eff[REF_FRAC-1:0];
    res_sh  = {res, {REF_FRAC{1'b0}}};
    nref_w  = NREF_BITS'(prod) + NREF_BITS'(res_sh)
            + NREF_BITS'(lo_prod[2*COEFF_BITS-1:COEFF_BITS]);

    sat_ref = 1'b0;
    if (nref_w > NREF_MAX) begin
      nref    = NREF_MAX[REF_BITS-1:0];
      sat_ref = 1'b1;
    end else if (nref_w < NREF_MIN) begin
      nref    = NREF_MIN[REF_BITS-1:0];
      sat_ref = 1'b1;
    end else begin
      nref = nref_w[REF_BITS-1:0];
    end

    result.phase_out = res;
    result.saturated = sat_out | sat_ref;
    result.next_ref  = nref;
  end

endmodule

/* src/smoothed_phase_unwrap_unit.sv */
// smoothed_phase_unwrap_unit: top level of the streaming phase unwrapper.
// Depends on spu_pkg, the channel interfaces in spu_if and spu_unwrap.
//
// Usage:
//  - sample: requests carry a wrapped phase (65536 per turn) and block_start,
//    which reloads the smoothed reference from that sample.
//  - result: one request per sample, in order: unwrapped phase and a
//    saturation flag.
//  - cfg: register writes (index 0 smooth_coeff, index 1 half_turn_mode),
//    always ready; write only while no sample is in flight. Other indexes
//    are ignored.
// Timing: one sample per cycle sustained while result.ready stays high. A sample
// passes through an input register, then a single pass of unwrap, saturation
// and the smoothing multiply into the result register, which drives result
// valid.
// The reference updates when a sample moves into the result register, so
// the next sample sees the updated reference even at full rate.
// Reset (rst, synchronous): clears the pipeline valids, the reference to 0,
// smooth_coeff to 58982 (about 0.9) and half_turn_mode to 0.
// Stall: if result.ready is low the result register holds; the input
// register still takes one more sample, then sample.ready drops until the
// result is taken.
module smoothed_phase_unwrap_unit (
  input  logic          clk,
  input  logic          rst,
  spu_in_if.sink        sample,
  spu_out_if.source     result,
  spu_cfg_if.sink       cfg
);
  import spu_pkg::*;

  // Configuration registers
  coeff_t      smooth_coeff;
  logic        half_turn_mode;

  // Input register
  logic        s1_valid;
  phase_t      s1_phase;
  logic        s1_start;

  // Result register and running reference
  logic        out_valid;
  phase_t      out_phase;
  logic        out_sat;
  ref_t        smoothed_ref;

  logic        out_free;
  logic        advance;
  logic        s1_load;
  spu_result_t step;

  assign out_free = ~out_valid | result.ready;
  assign advance  = s1_valid & out_free;
  // Input register frees up whenever its item moves on this cycle.
  assign sample.ready = ~s1_valid | out_free;
  assign s1_load      = sample.valid & sample.ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_coeff   <= COEFF_RESET;
      half_turn_mode <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SMOOTH_COEFF: smooth_coeff   <= cfg.data;
        CFG_HALF_TURN:    half_turn_mode <= cfg.data[0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_phase <= sample.phase_in;
      s1_start <= sample.block_start;
    end
  end

  spu_unwrap u_unwrap (
    .smoothed_ref   (smoothed_ref),
    .phase_in       (s1_phase),
    .block_start    (s1_start),
    .smooth_coeff   (smooth_coeff),
    .half_turn_mode (half_turn_mode),
    .result         (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      smoothed_ref <= '0;
    end else begin
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (advance) begin
        smoothed_ref <= step.next_ref;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_phase <= step.phase_out;
      out_sat   <= step.saturated;
    end
  end

  assign result.valid     = out_valid;
  assign result.phase_out = out_phase;
  assign result.saturated = out_sat;

`ifndef SYNTHESIS
  // An accepted sample always lands in the input register.
  a_load_lands: assert property (@(posedge clk) disable iff (rst)
    s1_load |=> s1_valid)
    else $error("accepted sample not held in input register");

  // The reference moves only when a sample enters the result register.
  a_ref_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(smoothed_ref))
    else $error("reference changed without a sample");

  // A new result can only come from an item that sat in the input register.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared with no sample in flight");
`endif

endmodule

/* dv/spu_unwrap_scoreboard.sv */
// spu_unwrap_scoreboard: watches the sample, result and cfg channels, predicts each unwrapped
// result and compares it in order. Depends on spu_pkg and the channel interfaces in spu_if.
module spu_unwrap_scoreboard (
  input  logic clk,
  input  logic rst,
  spu_in_if    sample,
  spu_out_if   result,
  spu_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding
);
  import spu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PHASE_TOP    = (longint'(1) <<< (PHASE_BITS - 1)) - 1;
  localparam longint PHASE_BOTTOM = -PHASE_TOP - 1;
  localparam longint REF_ONE      = longint'(1) <<< REF_FRAC;

  typedef struct packed {
    phase_t phase_out;
    logic   saturated;
  } unwrap_t;

  unwrap_t expected_unwraps[$];
  ref_t    unwrap_ref;
  coeff_t  smooth_coeff;
  logic    half_turn;
  int      fail_count = 0;
  int      result_idx = 0;

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // One sample through the unwrapper; updates the tracked reference.
  function automatic unwrap_t unwrap_sample(input phase_t ph, input logic start);
    longint  p, r, per, per16, rm, pm, d0, res, lo, hi, c, nref;
    unwrap_t u;
    p = longint'(ph);
    if (start)
      unwrap_ref = ref_t'(p <<< REF_FRAC);
    r     = longint'(unwrap_ref);
    per   = longint'(1) <<< (half_turn ? TURN_FRAC_BITS - 1 : TURN_FRAC_BITS);
    per16 = per <<< REF_FRAC;
    rm    = r & (per16 - 1);
    pm    = (p & (per - 1)) <<< REF_FRAC;
    d0    = magnitude(pm - rm);
    // strict compares: a tie keeps the unshifted remainder
    if (magnitude(pm - per16 - rm) < d0)
      pm = pm - per16;
    else if (magnitude(pm + per16 - rm) < d0)
      pm = pm + per16;
    res = ((r - rm) >>> REF_FRAC) + (pm >>> REF_FRAC);
    u.saturated = 1'b0;
    if (res > PHASE_TOP) begin
      res = PHASE_TOP;
      u.saturated = 1'b1;
    end else if (res < PHASE_BOTTOM) begin
      res = PHASE_BOTTOM;
      u.saturated = 1'b1;
    end
    // floor of c*ref + (1-c)*out, split so the fraction rounds down
    c    = longint'(smooth_coeff);
    lo   = r & 64'hFFFF;
    hi   = (r - lo) >>> REF_FRAC;
    nref = c * hi + (REF_ONE - c) * res + ((c * lo) >>> REF_FRAC);
    if (nref > PHASE_TOP * REF_ONE) begin
      nref = PHASE_TOP * REF_ONE;
      u.saturated = 1'b1;
    end else if (nref < PHASE_BOTTOM * REF_ONE) begin
      nref = PHASE_BOTTOM * REF_ONE;
      u.saturated = 1'b1;
    end
    unwrap_ref  = ref_t'(nref);
    u.phase_out = phase_t'(res);
    return u;
  endfunction

  always @(posedge clk) begin
    unwrap_t want;
    if (rst) begin
      unwrap_ref   = '0;
      smooth_coeff = COEFF_RESET;
      half_turn    = 1'b0;
      expected_unwraps.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_unwraps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result %0d with no sample pending: phase_out=%0d saturated=%b",
                     $realtime, result_idx, result.phase_out, result.saturated);
        end else begin
          want = expected_unwraps.pop_front();
          if (want.phase_out !== result.phase_out || want.saturated !== result.saturated) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: result %0d: expected phase_out=%0d saturated=%b, got %0d %b",
                       $realtime, result_idx, want.phase_out, want.saturated,
                       result.phase_out, result.saturated);
          end
        end
        result_idx++;
      end
      if (sample.valid && sample.ready)
        expected_unwraps.push_back(unwrap_sample(sample.phase_in, sample.block_start));
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_SMOOTH_COEFF: smooth_coeff = cfg.data;
          CFG_HALF_TURN:    half_turn = cfg.data[0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_unwraps.size();
    mismatches  <= fail_count;
  end

endmodule

/* dv/smoothed_phase_unwrap_unit_test.sv */
// smoothed_phase_unwrap_unit_test: drives samples and register writes into the phase unwrapper
// under random sender gaps and result stalls; depends on spu_pkg, spu_if and spu_unwrap_scoreboard.
module smoothed_phase_unwrap_unit_test;
  import spu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int       STALL_LIMIT    = 1000;   // cycles with no request moving on any channel
  localparam int       PHASE_ITEMS    = 230;    // random samples per config phase
  localparam int       NUM_PHASES     = 6;
  localparam cfg_idx_t UNUSED_REG     = cfg_idx_t'(2);
  localparam longint   PHASE_TOP      = (longint'(1) <<< (PHASE_BITS - 1)) - 1;
  localparam longint   PHASE_BOTTOM   = -PHASE_TOP - 1;

  // Opening requests under reset config: {block_start, phase_in}
  localparam logic [32:0] OPENING_ITEMS [20] = '{
    {1'b0, 32'h0000_0000},  // no block yet, reference still zero
    {1'b0, 32'h0000_8000},  // exactly half a turn from the reference: tie keeps it
    {1'b1, 32'hFFFF_8000},  // block opens at minus half a turn
    {1'b1, 32'h7FFF_FFFF},  // reference at the top of the range
    {1'b0, 32'h0000_0010},  // wraps upward past the top: output clips high
    {1'b1, 32'h8000_0000},  // reference at the bottom of the range
    {1'b0, 32'hFFFF_FFF0},  // wraps downward past the bottom: output clips low
    {1'b1, 32'h0000_FFFF},
    {1'b0, 32'h0000_0000},  // crosses the turn boundary
    {1'b0, 32'h0001_0000},  // bits above the turn only move the sample by whole turns
    {1'b0, 32'hFFFF_FFFF},
    {1'b1, 32'h1234_5678},
    {1'b0, 32'hEDCB_A987},
    {1'b0, 32'h0000_C000},
    {1'b0, 32'h0000_4000},
    {1'b1, 32'h5555_5555},
    {1'b0, 32'hAAAA_AAAA},
    {1'b1, 32'h7FFF_8000},
    {1'b0, 32'h0000_0000},
    {1'b0, 32'h8000_8000}
  };

  logic clk = 1'b0;
  logic rst;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   quiet_cycles = 0;
  int   mismatches;
  int   outstanding;

  spu_in_if  sample_ch ();
  spu_out_if result_ch ();
  spu_cfg_if cfg_ch ();

  smoothed_phase_unwrap_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  spu_unwrap_scoreboard u_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  // Result side: ready drops at random per cycle, at the rate the current phase sets.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: a run where nothing moves for too long is a hang.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One sample request; valid stays high afterward so back-to-back requests need no
  // second assignment in the same step. A random gap lowers it first.
  task automatic send_sample(input phase_t phase, input logic start);
    if ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.phase_in    <= phase;
    sample_ch.block_start <= start;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // Register write request; caller lowers cfg valid after the last write of a group.
  task automatic write_reg(input cfg_idx_t idx, input coeff_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has been taken.
  // The scoreboard's count is registered, hence the do-while.
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Random samples: mostly blocks that follow a drifting phase track, the rest noise,
  // tracks near the range ends (saturation) and tracks with no opening flag.
  task automatic run_phase(input int n_items);
    int     sent;
    int     pick;
    int     len;
    int     shape;
    logic   broken;
    longint max_step;
    longint track;
    phase_t wrapped;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          send_sample(phase_t'($urandom), ($urandom_range(7) == 0));
      end else begin
        len = $urandom_range(1, 40);
        if (pick < 30)
          track = $urandom_range(1) ? PHASE_TOP - longint'($urandom_range(200000))
                                    : PHASE_BOTTOM + longint'($urandom_range(200000));
        else
          track = longint'(phase_t'($urandom));
        case ($urandom_range(3))
          0:       max_step = 200;
          1:       max_step = 8000;
          2:       max_step = 30000;
          default: max_step = 70000;   // steps beyond half a turn: ambiguous unwraps
        endcase
        shape  = $urandom_range(2);
        broken = ($urandom_range(9) == 0);
        for (int i = 0; i < len; i++) begin
          if (i == 0) begin
            send_sample(phase_t'(track), !broken);
          end else begin
            track = track + longint'($urandom_range(2 * max_step)) - max_step;
            if ($urandom_range(19) == 0) begin
              wrapped = phase_t'($urandom);       // glitch inside the block
            end else begin
              case (shape)
                0:       wrapped = {16'h0000, track[15:0]};
                1:       wrapped = {{16{track[15]}}, track[15:0]};
                default: begin
                  wrapped       = phase_t'($urandom);
                  wrapped[15:0] = track[15:0];
                end
              endcase
            end
            send_sample(wrapped, 1'b0);
          end
        end
      end
      sent += len;
    end
  endtask

  initial begin
    coeff_t coeff;
    coeff_t mode_word;
    logic   half;

    rst                   <= 1'b1;
    sample_ch.valid       <= 1'b0;
    sample_ch.phase_in    <= '0;
    sample_ch.block_start <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_SMOOTH_COEFF;
    cfg_ch.data           <= '0;
    src_idle_pct          <= 37;
    sink_idle_pct         <= 67;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed requests run on the reset values of both registers.
    foreach (OPENING_ITEMS[i])
      send_sample(phase_t'(OPENING_ITEMS[i][31:0]), OPENING_ITEMS[i][32]);
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // receiver-heavy stalls, then sender-heavy gaps, then full rate
      if (ph < 2) begin
        src_idle_pct  <= 37;
        sink_idle_pct <= 67;
      end else if (ph < 4) begin
        src_idle_pct  <= 67;
        sink_idle_pct <= 37;
      end else begin
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
      end
      case (ph)
        0: begin
          coeff = '0;                  // reference follows the output exactly
          half  = 1'b0;
        end
        1: begin
          coeff = '1;                  // reference nearly frozen
          half  = 1'b1;
        end
        2: begin
          coeff = coeff_t'($urandom);
          half  = 1'b0;
        end
        3: begin
          coeff = coeff_t'(1);
          half  = 1'b1;
        end
        4: begin
          coeff = coeff_t'($urandom);
          half  = logic'($urandom_range(1));
        end
        default: begin
          coeff = COEFF_RESET;
          half  = 1'b0;
        end
      endcase
      // upper data bits of the mode register carry noise; only bit 0 counts
      mode_word    = coeff_t'($urandom);
      mode_word[0] = half;
      if (ph == 0)
        write_reg(UNUSED_REG, coeff_t'($urandom));
      write_reg(CFG_SMOOTH_COEFF, coeff);
      write_reg(CFG_HALF_TURN, mode_word);
      cfg_ch.valid <= 1'b0;
      run_phase(PHASE_ITEMS);
      drain_results();
    end

    // tail: catch any result the block emits with nothing pending
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
src/spu_pkg.sv
src/spu_if.sv
src/spu_unwrap.sv
src/smoothed_phase_unwrap_unit.sv
dv/spu_unwrap_scoreboard.sv
dv/smoothed_phase_unwrap_unit_test.sv
